### hdl/cac_pkg.sv
// Shared types and constants for the card access controller.
// Has no dependencies; cac_slot_engine and card_access_controller_unit import it.
`default_nettype none

package cac_pkg;

    localparam int SLOTS      = 128;
    localparam int FIRST_SLOT = 0;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CARD_W     = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [SLOT_W-1:0] FIRST_IDX = SLOT_W'(FIRST_SLOT);
    localparam logic [SLOT_W-1:0] LAST_IDX  = SLOT_W'(SLOTS - 1);

    // configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_ADD_SUP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERASE_SUP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALL_SUP   = 2'd2;

    localparam logic [CARD_W-1:0] ADD_SUP_RST   = 16'd24151;
    localparam logic [CARD_W-1:0] ERASE_SUP_RST = 16'd35907;
    localparam logic [CARD_W-1:0] ALL_SUP_RST   = 16'd41255;
    localparam logic [CARD_W-1:0] EMPTY_CARD    = 16'h0000;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_OPEN  = 3'd1,
        MODE_CLOSE = 3'd2,
        MODE_DEL   = 3'd3,
        MODE_ADD   = 3'd4
    } t_mode;

    localparam logic [1:0] DOOR_NONE   = 2'd0;
    localparam logic [1:0] DOOR_OPEN   = 2'd1;
    localparam logic [1:0] DOOR_CLOSE  = 2'd2;
    localparam logic [1:0] DOOR_EXTEND = 2'd3;

    localparam logic [1:0] GRN_KEEP  = 2'd0;
    localparam logic [1:0] GRN_OFF   = 2'd1;
    localparam logic [1:0] GRN_ON    = 2'd2;
    localparam logic [1:0] GRN_BLINK = 2'd3;

    localparam logic [1:0] RED_KEEP  = 2'd0;
    localparam logic [1:0] RED_OFF   = 2'd1;
    localparam logic [1:0] RED_FLASH = 2'd2;

    localparam logic [2:0] TRES_NONE    = 3'd0;
    localparam logic [2:0] TRES_ADDED   = 3'd1;
    localparam logic [2:0] TRES_ERASED  = 3'd2;
    localparam logic [2:0] TRES_CLEARED = 3'd3;
    localparam logic [2:0] TRES_PRESENT = 3'd4;
    localparam logic [2:0] TRES_MISSING = 3'd5;
    localparam logic [2:0] TRES_FULL    = 3'd6;

    typedef enum logic [2:0] {
        EV_REG,
        EV_NEW,
        EV_SADD,
        EV_SDEL,
        EV_SALL,
        EV_TIME
    } t_event;

    typedef enum logic [2:0] {
        ST_BOOT,
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SWEEP
    } t_ctl_state;

    typedef enum logic [1:0] {
        E_IDLE,
        E_SCAN,
        E_DRAIN,
        E_CLEAR
    } t_eng_state;

    typedef struct packed {
        logic              kind;
        logic [CARD_W-1:0] card_number;
    } t_in_word;

    typedef struct packed {
        logic [2:0] mode_after;
        logic [1:0] door_action;
        logic [1:0] green_led;
        logic [1:0] red_led;
        logic       start_wait_timer;
        logic       reader_reenable;
        logic [2:0] table_result;
        logic [6:0] slot_index;
    } t_out_word;

    typedef struct packed {
        logic              scan;
        logic              clr;
        logic              wr;
        logic [CARD_W-1:0] num;
        logic [SLOT_W-1:0] wr_addr;
        logic [CARD_W-1:0] wr_data;
    } t_eng_cmd;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic              hit;
        logic [SLOT_W-1:0] hit_idx;
        logic              free;
        logic [SLOT_W-1:0] free_idx;
    } t_eng_stat;

endpackage

`default_nettype wire

### hdl/cac_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cac_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### hdl/cac_slot_engine.sv
// Slot table engine: owns the card slot RAM, walks it for lookups and clears, and takes single slot writes.
// Depends on cac_pkg and cac_ram.
`default_nettype none

module cac_slot_engine (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire cac_pkg::t_eng_cmd  i_cmd,
    output cac_pkg::t_eng_stat      o_stat
);

    import cac_pkg::*;

    t_eng_state        r_state, n_state;
    logic [SLOT_W-1:0] r_addr, n_addr;
    logic [SLOT_W-1:0] r_raddr;
    logic              r_rvld;
    logic [CARD_W-1:0] r_num, n_num;
    logic              r_hit, n_hit;
    logic [SLOT_W-1:0] r_hit_idx, n_hit_idx;
    logic              r_free, n_free;
    logic [SLOT_W-1:0] r_free_idx, n_free_idx;
    logic              r_done;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    logic [CARD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [CARD_W-1:0] ram_rdata;

    cac_ram #(
        .WIDTH (CARD_W),
        .DEPTH (SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        n_num   = r_num;
        case (r_state)
            E_IDLE: begin
                if (i_cmd.clr) begin
                    n_state = E_CLEAR;
                    n_addr  = '0;
                end else if (i_cmd.scan) begin
                    n_state = E_SCAN;
                    n_addr  = FIRST_IDX;
                    n_num   = i_cmd.num;
                end
            end
            E_SCAN: begin
                if (r_addr == LAST_IDX) begin
                    n_state = E_DRAIN;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            E_DRAIN: n_state = E_IDLE;
            E_CLEAR: begin
                if (r_addr == LAST_IDX) begin
                    n_state = E_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            default: n_state = E_IDLE;
        endcase
    end

    // RAM port control
    always_comb begin
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = i_cmd.wr_addr;
        ram_wdata = i_cmd.wr_data;
        case (r_state)
            E_IDLE:  ram_we = i_cmd.wr;
            E_SCAN:  ram_re = 1'b1;
            E_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr;
                ram_wdata = EMPTY_CARD;
            end
            default: ram_we = 1'b0;
        endcase
    end

    // first match of the card and first empty slot, lowest slot first
    always_comb begin
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_free     = r_free;
        n_free_idx = r_free_idx;
        if (r_state == E_IDLE && i_cmd.scan && !i_cmd.clr) begin
            n_hit  = 1'b0;
            n_free = 1'b0;
        end else if (r_rvld) begin
            if (!r_hit && ram_rdata == r_num) begin
                n_hit     = 1'b1;
                n_hit_idx = r_raddr;
            end
            if (!r_free && ram_rdata == EMPTY_CARD) begin
                n_free     = 1'b1;
                n_free_idx = r_raddr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_CLEAR;
            r_addr  <= '0;
            r_rvld  <= 1'b0;
            r_done  <= 1'b0;
            r_hit   <= 1'b0;
            r_free  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_rvld  <= (r_state == E_SCAN);
            r_done  <= (r_state == E_DRAIN);
            r_hit   <= n_hit;
            r_free  <= n_free;
        end
    end

    always_ff @(posedge i_clk) begin
        r_raddr    <= r_addr;
        r_num      <= n_num;
        r_hit_idx  <= n_hit_idx;
        r_free_idx <= n_free_idx;
    end

    assign o_stat.busy     = (r_state != E_IDLE);
    assign o_stat.done     = r_done;
    assign o_stat.hit      = r_hit;
    assign o_stat.hit_idx  = r_hit_idx;
    assign o_stat.free     = r_free;
    assign o_stat.free_idx = r_free_idx;

    a_done_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state == E_DRAIN))
        else $error("lookup done without a finished walk");

    a_write_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr || i_cmd.scan || i_cmd.clr) |-> (r_state == E_IDLE))
        else $error("table command while engine busy");

    a_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_hit) |-> (r_hit_idx >= FIRST_IDX))
        else $error("hit below first searched slot");

endmodule

`default_nettype wire

### hdl/card_access_controller_unit.sv
// Card access controller top level: input decode, mode machine, result register.
// Depends on cac_pkg and cac_slot_engine.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_word) takes one word: a card
//   read or a timer timeout. Output channel (o_out_valid / i_out_stall /
//   o_out_word) returns exactly one result word per input word, in order.
//   A card read walks the slot RAM one slot per cycle, and its result is
//   registered once the walk is done and the output register is free; a
//   timeout skips the walk and its result is registered once the output
//   register is free. Erase-all then sweeps all SLOTS entries before the
//   next word is taken. One word is in work at a time, and a card read must
//   walk the slot RAM through its single read port.
//   A new word may be taken while the previous result waits on i_out_stall;
//   the following result is held back until the output register frees up.
//   After reset the slot RAM is cleared, one slot per cycle, with o_in_stall
//   high; configuration writes are taken at any time but only while the
//   block is idle do they have defined effect.
`default_nettype none

module card_access_controller_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire cac_pkg::t_in_word                 i_in_word,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output cac_pkg::t_out_word                     o_out_word,
    input  wire logic                              i_cfg_we,
    input  wire logic [cac_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [cac_pkg::CARD_W-1:0]        i_cfg_wdata
);

    import cac_pkg::*;

    t_ctl_state        r_state, n_state;
    t_mode             r_mode;
    logic              r_green_tog;
    logic              r_kind;
    logic [CARD_W-1:0] r_num;
    logic [CARD_W-1:0] r_add_sup, r_erase_sup, r_all_sup;
    logic              r_out_vld;
    t_out_word         r_out;

    t_eng_cmd          eng_cmd;
    t_eng_stat         eng_stat;

    logic              in_acc;
    logic              ld;
    t_event            ev;
    t_out_word         dec;
    logic              dec_tog;
    logic              dec_wr;
    logic [SLOT_W-1:0] dec_waddr;
    logic [CARD_W-1:0] dec_wdata;
    logic              dec_clr;
    logic              fallback;

    cac_slot_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (eng_cmd),
        .o_stat  (eng_stat)
    );

    assign in_acc = i_in_valid && !o_in_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_BOOT:   if (!eng_stat.busy) n_state = ST_IDLE;
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_in_word.kind ? ST_DECIDE : ST_SCAN;
                end
            end
            ST_SCAN:   if (eng_stat.done) n_state = ST_DECIDE;
            ST_DECIDE: begin
                if (ld) begin
                    n_state = dec_clr ? ST_SWEEP : ST_IDLE;
                end
            end
            ST_SWEEP:  if (!eng_stat.busy) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_stall      = (r_state != ST_IDLE);
        ld              = (r_state == ST_DECIDE) && (!r_out_vld || !i_out_stall);
        eng_cmd.scan    = (r_state == ST_IDLE) && i_in_valid && !i_in_word.kind;
        eng_cmd.num     = i_in_word.card_number;
        eng_cmd.clr     = ld && dec_clr;
        eng_cmd.wr      = ld && dec_wr;
        eng_cmd.wr_addr = dec_waddr;
        eng_cmd.wr_data = dec_wdata;
    end

    // event decode; supervisor compares in priority order
    always_comb begin
        if (r_kind) begin
            ev = EV_TIME;
        end else if (r_num == r_add_sup) begin
            ev = EV_SADD;
        end else if (r_num == r_erase_sup) begin
            ev = EV_SDEL;
        end else if (r_num == r_all_sup) begin
            ev = EV_SALL;
        end else begin
            ev = eng_stat.hit ? EV_REG : EV_NEW;
        end
    end

    // mode machine decision
    always_comb begin
        dec       = '0;
        dec.mode_after = MODE_IDLE;
        dec_tog   = r_green_tog;
        dec_wr    = 1'b0;
        dec_waddr = eng_stat.hit_idx;
        dec_wdata = EMPTY_CARD;
        dec_clr   = 1'b0;
        fallback  = 1'b0;
        case (r_mode)
            MODE_OPEN: begin
                if (ev == EV_TIME) begin
                    dec.mode_after  = MODE_CLOSE;
                    dec.door_action = DOOR_CLOSE;
                end else if (ev == EV_REG) begin
                    dec.mode_after  = MODE_OPEN;
                    dec.door_action = DOOR_EXTEND;
                end else begin
                    fallback = 1'b1;
                end
            end
            MODE_CLOSE: begin
                if (ev == EV_TIME) begin
                    dec.reader_reenable = 1'b1;
                    dec.green_led       = GRN_OFF;
                    dec.red_led         = RED_OFF;
                end else if (ev == EV_REG) begin
                    dec.mode_after = MODE_CLOSE;
                    dec.green_led  = r_green_tog ? GRN_ON : GRN_OFF;
                    dec_tog        = !r_green_tog;
                end else begin
                    fallback = 1'b1;
                end
            end
            MODE_DEL: begin
                if (ev == EV_REG) begin
                    dec.green_led = GRN_OFF;
                    if (eng_stat.hit) begin
                        dec_wr           = 1'b1;
                        dec.red_led      = RED_FLASH;
                        dec.table_result = TRES_ERASED;
                        dec.slot_index   = 7'(eng_stat.hit_idx);
                    end else begin
                        dec.table_result = TRES_MISSING;
                    end
                end else begin
                    fallback = 1'b1;
                end
            end
            MODE_ADD: begin
                if (ev == EV_NEW) begin
                    dec.green_led = GRN_OFF;
                    if (eng_stat.hit) begin
                        dec.table_result = TRES_PRESENT;
                    end else begin
                        dec.red_led = RED_FLASH;
                        if (eng_stat.free) begin
                            dec_wr           = 1'b1;
                            dec_waddr        = eng_stat.free_idx;
                            dec_wdata        = r_num;
                            dec.table_result = TRES_ADDED;
                            dec.slot_index   = 7'(eng_stat.free_idx);
                        end else begin
                            dec.table_result = TRES_FULL;
                        end
                    end
                end else begin
                    fallback = 1'b1;
                end
            end
            default: begin
                if (ev == EV_REG) begin
                    dec.mode_after  = MODE_OPEN;
                    dec.door_action = DOOR_OPEN;
                end else if (ev == EV_SALL) begin
                    dec_clr          = 1'b1;
                    dec.red_led      = RED_FLASH;
                    dec.table_result = TRES_CLEARED;
                end else if (ev == EV_SDEL) begin
                    dec.mode_after       = MODE_DEL;
                    dec.green_led        = GRN_BLINK;
                    dec.start_wait_timer = 1'b1;
                end else if (ev == EV_SADD) begin
                    dec.mode_after       = MODE_ADD;
                    dec.green_led        = GRN_BLINK;
                    dec.start_wait_timer = 1'b1;
                end else begin
                    fallback = 1'b1;
                end
            end
        endcase
        if (fallback) begin
            dec            = '0;
            dec.mode_after = MODE_IDLE;
            dec.green_led  = GRN_OFF;
            dec.red_led    = RED_OFF;
            dec_tog        = r_green_tog;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_BOOT;
            r_mode      <= MODE_IDLE;
            r_green_tog <= 1'b0;
            r_out_vld   <= 1'b0;
            r_add_sup   <= ADD_SUP_RST;
            r_erase_sup <= ERASE_SUP_RST;
            r_all_sup   <= ALL_SUP_RST;
        end else begin
            r_state <= n_state;
            if (ld) begin
                r_mode      <= t_mode'(dec.mode_after);
                r_green_tog <= dec_tog;
                r_out_vld   <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ADD_SUP:   r_add_sup   <= i_cfg_wdata;
                    CFG_ERASE_SUP: r_erase_sup <= i_cfg_wdata;
                    CFG_ALL_SUP:   r_all_sup   <= i_cfg_wdata;
                    default:       r_all_sup   <= r_all_sup;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind <= i_in_word.kind;
            r_num  <= i_in_word.card_number;
        end
        if (ld) begin
            r_out <= dec;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    a_load_from_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == ST_DECIDE))
        else $error("result loaded outside decide");

    a_accept_engine_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> !eng_stat.busy)
        else $error("word accepted while slot table busy");

    a_mode_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !ld |=> $stable(r_mode))
        else $error("mode changed without a result");

    a_slot_only_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ld && dec.slot_index != 7'd0) |->
            (dec.table_result == TRES_ADDED || dec.table_result == TRES_ERASED))
        else $error("slot index without a table write");

endmodule

`default_nettype wire
